// File: design/psieve_pkg.sv
// ----------------------------------------------------------------------------
// psieve_pkg
// Shared constants and controller/datapath interface types for the prime
// sieve table.
// ----------------------------------------------------------------------------
package psieve_pkg;

  // Table depth and derived widths
  localparam int MAX_LIMIT = 4096;
  localparam int ADDR_W    = $clog2(MAX_LIMIT);

  // Fixed field widths
  localparam int LIMIT_W = 13;
  localparam int QUERY_W = 12;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(MAX_LIMIT);
  localparam logic [LIMIT_W-1:0] FIRST_PRIME = LIMIT_W'(2);

  // Commands from controller to datapath
  typedef struct packed {
    logic i_clr;      // i := 0
    logic i_first;    // i := first prime
    logic i_inc;      // i := i + 1
    logic j_init;     // j := 2 * i
    logic j_step;     // j := j + i
    logic wr_en;      // write the bit table
    logic wr_mark;    // 1: clear entry j, 0: fill entry i
    logic rd_query;   // read address from query port, else from i
    logic q_load;     // capture range flag of accepted query
    logic out_load;   // load result register
  } psieve_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic i_lt_n;
    logic j_lt_n;
    logic rd_bit;
  } psieve_sts_t;

endpackage

// File: design/prime_sieve_table_top.sv
// ----------------------------------------------------------------------------
// prime_sieve_table_top
// Primality lookup table for numbers below a programmable limit, built by
// the sieve of Eratosthenes.
// ----------------------------------------------------------------------------
// The block answers, for each query beat, whether the number is prime, or
// flags it out of range when it is at or above the limit (the effective
// limit saturates at 4096; a limit of zero makes every query out of
// range). The table is built on the first query after reset or after a
// limit write: that query is held off while the controller fills the table,
// then walks every candidate from two upward (a registered read of the bit
// table for each) and, for each candidate still marked, clears its
// multiples one per cycle. Once built, a query is served from one
// registered read of the bit table, which has one write and one read port:
// the result register loads in the cycle after the query is accepted, and
// the next query beat is held off until that result has loaded. A result
// waiting in the output register does not block the next query unless the
// output is also stalled. Write the limit only while the block is idle.
// ----------------------------------------------------------------------------
module prime_sieve_table_top
  import psieve_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Configuration: limit register
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  // Query beats
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [QUERY_W-1:0] in_query_value,
  // Result beats
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_prime_flag,
  output logic               out_out_of_range
);

  psieve_cmd_t cmd;
  psieve_sts_t sts;

  // Sequence the build and own the beat handshakes
  psieve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the limit, the counters, the bit table and the result register
  psieve_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_query_value   (in_query_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_prime_flag   (out_prime_flag),
    .out_out_of_range (out_out_of_range)
  );

endmodule

// File: design/psieve_dp.sv
// ----------------------------------------------------------------------------
// psieve_dp
// Datapath: limit register, sieve counters, primality bit table and result
// register.
// ----------------------------------------------------------------------------
module psieve_dp
  import psieve_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic [QUERY_W-1:0] in_query_value,
  input  psieve_cmd_t        cmd,
  output psieve_sts_t        sts,
  output logic               out_prime_flag,
  output logic               out_out_of_range
);

  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] lim_eff;
  logic [LIMIT_W-1:0] i_r;
  logic [LIMIT_W-1:0] j_r;
  logic               prime_bits_r [MAX_LIMIT];
  logic               rd_bit_r;
  logic               oor_pend_r;
  logic               prime_flag_r;
  logic               oor_r;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_data;
  logic [ADDR_W-1:0]  rd_addr;

  // Saturate the register to the table depth
  assign lim_eff = (limit_r > LIMIT_MAX) ? LIMIT_MAX : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.i_clr) begin
      i_r <= '0;
    end else if (cmd.i_first) begin
      i_r <= FIRST_PRIME;
    end else if (cmd.i_inc) begin
      i_r <= i_r + LIMIT_W'(1);
    end
    if (cmd.j_init) begin
      j_r <= {i_r[LIMIT_W-2:0], 1'b0};
    end else if (cmd.j_step) begin
      j_r <= j_r + i_r;
    end
  end

  assign wr_addr = cmd.wr_mark ? j_r[ADDR_W-1:0] : i_r[ADDR_W-1:0];
  assign wr_data = cmd.wr_mark ? 1'b0 : (i_r >= FIRST_PRIME);
  assign rd_addr = cmd.rd_query ? ADDR_W'(in_query_value) : i_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      prime_bits_r[wr_addr] <= wr_data;
    end
    rd_bit_r <= prime_bits_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      oor_pend_r <= ({1'b0, in_query_value} >= lim_eff);
    end
    if (cmd.out_load) begin
      prime_flag_r <= rd_bit_r & ~oor_pend_r;
      oor_r        <= oor_pend_r;
    end
  end

  assign sts.i_lt_n = (i_r < lim_eff);
  assign sts.j_lt_n = (j_r < lim_eff);
  assign sts.rd_bit = rd_bit_r;

  assign out_prime_flag   = prime_flag_r;
  assign out_out_of_range = oor_r;

endmodule

// File: design/psieve_ctrl.sv
// ----------------------------------------------------------------------------
// psieve_ctrl
// Controller: sequences the table build and runs the query handshake.
// ----------------------------------------------------------------------------
module psieve_ctrl
  import psieve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  psieve_sts_t sts,
  output psieve_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MARK,
    ST_SERVE
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != ST_SERVE) || pend_r || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.i_clr = 1'b1;
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (sts.i_lt_n) begin
          cmd.wr_en = 1'b1;
          cmd.i_inc = 1'b1;
        end else begin
          cmd.i_first = 1'b1;
          state_nxt   = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_nxt = sts.i_lt_n ? ST_SCAN_CHK : ST_SERVE;
      end
      ST_SCAN_CHK: begin
        if (sts.rd_bit) begin
          cmd.j_init = 1'b1;
          state_nxt  = ST_MARK;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_MARK: begin
        if (sts.j_lt_n) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_mark = 1'b1;
          cmd.j_step  = 1'b1;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SERVE: begin
        cmd.rd_query = 1'b1;
        cmd.q_load   = accept;
      end
      default: state_nxt = ST_IDLE;
    endcase
    // A new limit invalidates the table
    if (cfg_wr_en) begin
      state_nxt = ST_IDLE;
    end
    cmd.out_load = pend_r;
  end

  always_comb begin
    pend_nxt      = accept;
    out_valid_nxt = out_valid_r;
    if (pend_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/psieve_checker.sv
// ----------------------------------------------------------------------------
// psieve_checker
// Port-level checks for the prime sieve table, bound to the top level.
// ----------------------------------------------------------------------------
module psieve_checker
  import psieve_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [QUERY_W-1:0] in_query_value,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_prime_flag,
  input logic               out_out_of_range
);

  logic in_beat;

  assign in_beat = in_valid && !in_stall;

  // A result is never both prime and out of range
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_prime_flag && out_out_of_range))
    else $error("result flagged prime and out of range");

  // Zero and one come back as not prime
  a_zero_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_query_value[QUERY_W-1:1] == '0)) |=> ##1
      (out_valid && !out_prime_flag))
    else $error("zero or one reported prime");

  // Even numbers other than two come back as not prime
  a_even: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && !in_query_value[0] && (in_query_value != QUERY_W'(2))) |=> ##1
      (out_valid && !out_prime_flag))
    else $error("even number reported prime");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_prime_flag) && $stable(out_out_of_range)))
    else $error("stalled result changed");

endmodule

bind prime_sieve_table_top psieve_checker u_psieve_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_query_value   (in_query_value),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_prime_flag   (out_prime_flag),
  .out_out_of_range (out_out_of_range)
);
